### rtl/core/upd_pkg.sv
package upd_pkg;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = Q_PTR_W + 1;

	// up to three output bytes produced by one input beat
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [1:0] n;      // number of valid bytes, 1..3
		logic       last;   // final byte of this group ends the string
	} cmd_t;

endpackage

### rtl/core/upd_front.sv
module upd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	input  logic             q_full,
	output logic             in_ready,
	output logic             push,
	output upd_pkg::cmd_t    push_cmd
);

	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	typedef enum logic [2:0] {
		HS_NONE = 3'b001,
		HS_PCT  = 3'b010,
		HS_DIG  = 3'b100
	} hold_t;

	// {valid, nibble}
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

	hold_t      hold_q, hold_d;
	logic [7:0] digit_q;
	logic [4:0] lo, hi;
	logic       accept;
	logic       plain_hold;
	logic       use_plain;
	logic [1:0] prefix;
	logic [7:0] pl_byte;
	logic       pl_emit;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	assign lo = hex_nib(in_byte);
	assign hi = hex_nib(digit_q);

	// a lone percent sign gets held unless the string ends here
	assign plain_hold = (in_byte == CH_PERCENT) && !in_last;
	assign pl_emit    = !plain_hold;
	assign pl_byte    = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;

	always_comb begin
		push_cmd      = '0;
		push_cmd.last = in_last;
		use_plain     = 1'b1;
		prefix        = 2'd0;
		hold_d        = HS_NONE;
		unique case (hold_q)
			HS_NONE: begin
				prefix = 2'd0;
			end
			HS_PCT: begin
				if (lo[4] && !in_last) begin
					use_plain = 1'b0;
					hold_d    = HS_DIG;
				end else begin
					prefix = 2'd1;
				end
			end
			HS_DIG: begin
				if (hi[4] && lo[4]) begin
					use_plain   = 1'b0;
					push_cmd.b0 = {hi[3:0], lo[3:0]};
					push_cmd.n  = 2'd1;
				end else begin
					prefix = 2'd2;
				end
			end
			default: begin
				prefix = 2'd0;
			end
		endcase
		if (use_plain) begin
			if (plain_hold) begin
				hold_d = HS_PCT;
			end
			unique case (prefix)
				2'd1: begin
					push_cmd.b0 = CH_PERCENT;
					push_cmd.b1 = pl_byte;
				end
				2'd2: begin
					push_cmd.b0 = CH_PERCENT;
					push_cmd.b1 = digit_q;
					push_cmd.b2 = pl_byte;
				end
				default: begin
					push_cmd.b0 = pl_byte;
				end
			endcase
			push_cmd.n = prefix + {1'b0, pl_emit};
		end
		if (in_last) begin
			hold_d = HS_NONE;
		end
	end

	assign push = accept && (push_cmd.n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HS_NONE;
		end else if (accept) begin
			hold_q <= hold_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold_q == HS_PCT) begin
			digit_q <= in_byte;
		end
	end

`ifndef SYNTHESIS
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_last) |-> push)
		else $error("final beat of a string produced no output");
`endif

endmodule

### rtl/core/upd_queue.sv
module upd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  upd_pkg::cmd_t push_cmd,
	input  logic          pop,
	output upd_pkg::cmd_t head,
	output logic          empty,
	output logic          full
);

	upd_pkg::cmd_t                  mem_q [upd_pkg::Q_DEPTH];
	logic [upd_pkg::Q_PTR_W-1:0]    wr_q, rd_q;
	logic [upd_pkg::Q_CNT_W-1:0]    cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == upd_pkg::Q_CNT_W'(upd_pkg::Q_DEPTH));
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue pop while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= upd_pkg::Q_CNT_W'(upd_pkg::Q_DEPTH))
		else $error("queue count out of range");
`endif

endmodule

### rtl/core/upd_back.sv
module upd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  upd_pkg::cmd_t head,
	input  logic          empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          out_last
);

	logic [1:0] idx_q;
	logic       load, take, is_end;
	logic [7:0] sel;

	assign load   = !out_valid || out_ready;
	assign take   = load && !empty;
	assign is_end = (idx_q == (head.n - 2'd1));
	assign pop    = take && is_end;

	always_comb begin
		unique case (idx_q)
			2'd1:    sel = head.b1;
			2'd2:    sel = head.b2;
			default: sel = head.b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q     <= 2'd0;
		end else begin
			if (take) begin
				out_valid <= 1'b1;
				idx_q     <= is_end ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte <= sel;
			out_last <= head.last && is_end;
		end
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (idx_q < head.n))
		else $error("byte index beyond group size");
`endif

endmodule

### rtl/core/url_percent_decoder_top.sv
// Streaming form-urlencoded decoder: one encoded byte per input beat (tlast on
// the final byte of a string), decoded bytes out with tlast on the string's
// final output byte. '+' becomes a space, '%' plus two hex digits becomes one
// byte, and an unfinished or broken escape is passed through as is. Input is
// taken every cycle while the 4-entry group queue has room; output runs one
// byte per cycle while the queue holds data and m_tready is high, so a beat
// that expands to two or three bytes (a broken escape being flushed) holds
// the output for longer, and input stalls only once the queue fills. The
// front classifier writes the queue, and the back part serializes each
// group from the queue through the output register.
module url_percent_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast    // out_last
);

	upd_pkg::cmd_t push_cmd, head;
	logic          push, pop, empty, full;

	upd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.q_full   (full),
		.in_ready (s_tready),
		.push     (push),
		.push_cmd (push_cmd)
	);

	upd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	upd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
